// ===== hdl/npl_pkg.sv =====
package npl_pkg;
    localparam int unsigned FIELD_W = 32;           // coordinate field width
    localparam int unsigned DIFF_W  = 33;           // difference / magnitude width
    localparam int unsigned PROD_W  = 2 * DIFF_W;   // one product
    localparam int unsigned NUM_W   = 132;          // cross-product numerator
    localparam int unsigned DIST_W  = 64;           // Q32.32 distance
    localparam int unsigned IDX_W   = 16;           // reported index
    localparam int unsigned CFG_IW  = 3;            // register index width

    typedef logic [CFG_IW-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_START_X = 3'd0;
    localparam t_cfg_idx REG_START_Y = 3'd1;
    localparam t_cfg_idx REG_START_Z = 3'd2;
    localparam t_cfg_idx REG_END_X   = 3'd3;
    localparam t_cfg_idx REG_END_Y   = 3'd4;
    localparam t_cfg_idx REG_END_Z   = 3'd5;
    localparam t_cfg_idx REG_THRESH  = 3'd6;

    localparam logic [DIST_W-1:0] THRESH_RESET = 64'h0000_0001_0000_0000;
    localparam logic [DIST_W-1:0] DIST_SAT     = '1;
endpackage

// ===== hdl/npl_point_if.sv =====
interface npl_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               visible;
    logic               last;

    modport source (output valid, point_x, point_y, point_z, visible, last, input ready);
    modport sink   (input valid, point_x, point_y, point_z, visible, last, output ready);
endinterface

// ===== hdl/npl_result_if.sv =====
interface npl_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] nearest_index;

    modport source (output valid, found, nearest_index, input ready);
    modport sink   (input valid, found, nearest_index, output ready);
endinterface

// ===== hdl/npl_mul.sv =====
module npl_mul (
    input  logic                          i_clk,
    input  logic [npl_pkg::DIFF_W-1:0]    i_a,
    input  logic [npl_pkg::DIFF_W-1:0]    i_b,
    output logic [npl_pkg::PROD_W-1:0]    o_p
);
    import npl_pkg::*;

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;
endmodule

// ===== hdl/npl_div.sv =====
// restoring divider, one quotient bit per cycle
module npl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [npl_pkg::PROD_W-1:0]    i_hi,     // numerator high part, < den
    input  logic [npl_pkg::DIST_W-1:0]    i_lo,
    input  logic [npl_pkg::PROD_W-1:0]    i_den,
    output logic                          o_done,
    output logic [npl_pkg::DIST_W-1:0]    o_q
);
    import npl_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [PROD_W-1:0] r_rem;
    logic [DIST_W-1:0] r_lo;
    logic [DIST_W-1:0] r_q;
    logic [PROD_W:0]   trial;
    logic              ge;

    assign trial = {r_rem, r_lo[DIST_W-1]};
    assign ge    = trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_hi;
                r_lo   <= i_lo;
            end else if (r_busy) begin
                r_rem  <= ge ? PROD_W'(trial - {1'b0, i_den}) : PROD_W'(trial);
                r_lo   <= {r_lo[DIST_W-2:0], 1'b0};
                r_q    <= {r_q[DIST_W-2:0], ge};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

// ===== hdl/nearest_point_to_line.sv =====
// Nearest point to a 3-D line.
// The line runs through two endpoints held in configuration registers
// 0..5 (start x/y/z, end x/y/z, Q16.16); register 6 is the starting
// squared-distance limit (Q32.32, 1.0 after reset). Write them only idle.
// Points arrive as words on i_pt; each visible point gets its squared
// distance |d x (p - s)|^2 / |d|^2 (plain |p - s|^2 if the endpoints
// coincide), and a strictly smaller value becomes the new running best.
// A word with last set closes the run: one word on o_res gives found and
// the list position of the winner (0 if none), and the run restarts.
// A visible point takes 22 steps through the single shared 33x33
// multiplier, then runs the one-bit-per-cycle divider; a saturated or
// coincident-endpoint case skips the divider. An invisible point goes
// straight from idle to the update.
// i_pt.ready is high only while the sequencer is idle. The result sits in
// an output register; if it has not been taken when the next run closes,
// the sequencer holds that point until o_res drains.
// Reset (synchronous, active low) restores register defaults and clears
// the run and the result register.
module nearest_point_to_line #(
    parameter int unsigned MAX_POINTS  = 65536,
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  npl_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [npl_pkg::DIST_W-1:0]   i_cfg_data,
    npl_point_if.sink                    i_pt,
    npl_result_if.source                 o_res
);
    import npl_pkg::*;

    localparam int unsigned SH = FIELD_W - COORD_WIDTH;
    localparam logic [4:0] LAST_STEP = 5'd21;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_CHK, S_DIV, S_UPD} t_state;

    // low COORD_WIDTH bits, sign extended
    function automatic logic signed [DIFF_W-1:0] ext(input logic [FIELD_W-1:0] v);
        logic signed [FIELD_W-1:0] t;
        t = signed'(v << SH) >>> SH;
        return DIFF_W'(t);
    endfunction

    function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    // configuration
    logic [FIELD_W-1:0] r_sx, r_sy, r_sz, r_ex, r_ey, r_ez;
    logic [DIST_W-1:0]  r_thr;

    // run state
    logic [IDX_W-1:0]   r_pos, r_best_pos;
    logic [DIST_W-1:0]  r_best;
    logic               r_found;

    // per-item working registers
    t_state                    r_state;
    logic [4:0]                r_step;
    logic signed [DIFF_W-1:0]  r_dx, r_dy, r_dz, r_px, r_py, r_pz;
    logic                      r_vis, r_last;
    logic                      r_psign;     // sign of the product in flight
    logic [PROD_W-1:0]         r_den;       // |d|^2 (66 bits hold 3 * 2^64)
    logic [PROD_W-1:0]         r_plain;     // |p - s|^2
    logic [NUM_W-1:0]          r_num;
    logic signed [PROD_W:0]    r_cr;        // first half of a cross term
    logic [PROD_W-1:0]         r_c0, r_c1, r_c2;
    logic [DIST_W-1:0]         r_dist;

    // output register
    logic               r_ov, r_ofound;
    logic [IDX_W-1:0]   r_oidx;

    // shared multiplier
    logic signed [DIFF_W-1:0] op_a, op_b;   // signed operands (all steps but the cross-term squares)
    logic [DIFF_W-1:0]        mu_a, mu_b;
    logic                     use_sign;
    logic [PROD_W-1:0]        prod;
    logic signed [PROD_W:0]   sprod, cdiff;
    logic [PROD_W-1:0]        cmag;

    always_comb begin
        op_a     = '0;
        op_b     = '0;
        mu_a     = '0;
        mu_b     = '0;
        use_sign = 1'b1;
        unique case (r_step)
            5'd0:  begin op_a = r_dx; op_b = r_dx; end
            5'd1:  begin op_a = r_dy; op_b = r_dy; end
            5'd2:  begin op_a = r_dz; op_b = r_dz; end
            5'd3:  begin op_a = r_dy; op_b = r_pz; end
            5'd4:  begin op_a = r_dz; op_b = r_py; end
            5'd5:  begin op_a = r_dz; op_b = r_px; end
            5'd6:  begin op_a = r_dx; op_b = r_pz; end
            5'd7:  begin op_a = r_dx; op_b = r_py; end
            5'd8:  begin op_a = r_dy; op_b = r_px; end
            5'd9:  begin use_sign = 1'b0; mu_a = r_c0[65:33]; mu_b = r_c0[65:33]; end
            5'd10: begin use_sign = 1'b0; mu_a = r_c0[65:33]; mu_b = r_c0[32:0];  end
            5'd11: begin use_sign = 1'b0; mu_a = r_c0[32:0];  mu_b = r_c0[32:0];  end
            5'd12: begin use_sign = 1'b0; mu_a = r_c1[65:33]; mu_b = r_c1[65:33]; end
            5'd13: begin use_sign = 1'b0; mu_a = r_c1[65:33]; mu_b = r_c1[32:0];  end
            5'd14: begin use_sign = 1'b0; mu_a = r_c1[32:0];  mu_b = r_c1[32:0];  end
            5'd15: begin use_sign = 1'b0; mu_a = r_c2[65:33]; mu_b = r_c2[65:33]; end
            5'd16: begin use_sign = 1'b0; mu_a = r_c2[65:33]; mu_b = r_c2[32:0];  end
            5'd17: begin use_sign = 1'b0; mu_a = r_c2[32:0];  mu_b = r_c2[32:0];  end
            5'd18: begin op_a = r_px; op_b = r_px; end
            5'd19: begin op_a = r_py; op_b = r_py; end
            5'd20: begin op_a = r_pz; op_b = r_pz; end
            default: begin end
        endcase
        if (use_sign) begin
            mu_a = mag(op_a);
            mu_b = mag(op_b);
        end
    end

    npl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mu_a),
        .i_b   (mu_b),
        .o_p   (prod)
    );

    assign sprod = r_psign ? -signed'({1'b0, prod}) : signed'({1'b0, prod});
    assign cdiff = r_cr - sprod;
    assign cmag  = cdiff[PROD_W] ? PROD_W'(-cdiff) : PROD_W'(cdiff);

    // divider
    logic              div_start, div_done;
    logic [DIST_W-1:0] div_q;
    logic              hi_ge;

    assign hi_ge     = r_num[NUM_W-1:DIST_W] >= {2'b0, r_den};
    assign div_start = (r_state == S_CHK) && (r_den != '0) && !hi_ge;

    npl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_hi    (PROD_W'(r_num[NUM_W-1:DIST_W])),
        .i_lo    (r_num[DIST_W-1:0]),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // update decision
    logic [DIST_W-1:0] limit;
    logic              win, out_free, res_load;
    logic [IDX_W:0]    pos_inc;

    assign limit    = r_found ? r_best : r_thr;
    assign win      = r_vis && (limit > r_dist);
    assign out_free = !r_ov || o_res.ready;
    assign res_load = (r_state == S_UPD) && r_last && out_free;
    assign pos_inc  = {1'b0, r_pos} + 1'b1;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx  <= '0;
            r_sy  <= '0;
            r_sz  <= '0;
            r_ex  <= '0;
            r_ey  <= '0;
            r_ez  <= '0;
            r_thr <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_START_X: r_sx  <= i_cfg_data[FIELD_W-1:0];
                REG_START_Y: r_sy  <= i_cfg_data[FIELD_W-1:0];
                REG_START_Z: r_sz  <= i_cfg_data[FIELD_W-1:0];
                REG_END_X:   r_ex  <= i_cfg_data[FIELD_W-1:0];
                REG_END_Y:   r_ey  <= i_cfg_data[FIELD_W-1:0];
                REG_END_Z:   r_ez  <= i_cfg_data[FIELD_W-1:0];
                REG_THRESH:  r_thr <= i_cfg_data;
                default: begin end  // unmapped index ignored
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_pos      <= '0;
            r_best_pos <= '0;
            r_found    <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (res_load) r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_pt.valid) begin
                        r_dx   <= ext(r_ex) - ext(r_sx);
                        r_dy   <= ext(r_ey) - ext(r_sy);
                        r_dz   <= ext(r_ez) - ext(r_sz);
                        r_px   <= ext(i_pt.point_x) - ext(r_sx);
                        r_py   <= ext(i_pt.point_y) - ext(r_sy);
                        r_pz   <= ext(i_pt.point_z) - ext(r_sz);
                        r_vis  <= i_pt.visible;
                        r_last <= i_pt.last;
                        r_step <= '0;
                        r_state <= i_pt.visible ? S_MUL : S_UPD;
                    end
                end
                S_MUL: begin
                    r_psign <= use_sign && (op_a[DIFF_W-1] ^ op_b[DIFF_W-1]);
                    unique case (r_step)
                        5'd1:  r_den <= prod;
                        5'd2, 5'd3: r_den <= r_den + prod;
                        5'd4, 5'd6, 5'd8: r_cr <= sprod;
                        5'd5:  r_c0 <= cmag;
                        5'd7:  r_c1 <= cmag;
                        5'd9:  r_c2 <= cmag;
                        5'd10: r_num <= {prod, 66'b0};
                        5'd11, 5'd14, 5'd17: r_num <= r_num + {32'b0, prod, 34'b0};
                        5'd12, 5'd15, 5'd18: r_num <= r_num + {66'b0, prod};
                        5'd13, 5'd16: r_num <= r_num + {prod, 66'b0};
                        5'd19: r_plain <= prod;
                        5'd20, 5'd21: r_plain <= r_plain + prod;
                        default: begin end
                    endcase
                    r_step <= r_step + 5'd1;
                    if (r_step == LAST_STEP) r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_den == '0) begin
                        r_dist  <= (r_plain[PROD_W-1:DIST_W] != '0) ? DIST_SAT
                                                                   : r_plain[DIST_W-1:0];
                        r_state <= S_UPD;
                    end else if (hi_ge) begin
                        r_dist  <= DIST_SAT;
                        r_state <= S_UPD;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_dist  <= div_q;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (!r_last) begin
                        if (win) begin
                            r_best     <= r_dist;
                            r_best_pos <= r_pos;
                            r_found    <= 1'b1;
                        end
                        r_pos   <= (32'(pos_inc) >= 32'(MAX_POINTS)) ? '0
                                                                     : pos_inc[IDX_W-1:0];
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_ofound   <= r_found || win;
                        r_oidx     <= win ? r_pos : (r_found ? r_best_pos : '0);
                        r_pos      <= '0;
                        r_best_pos <= '0;
                        r_found    <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_pt.ready          = (r_state == S_IDLE);
    assign o_res.valid         = r_ov;
    assign o_res.found         = r_ofound;
    assign o_res.nearest_index = r_oidx;
endmodule

// ===== hdl/npl_checker.sv =====
module npl_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_found,
    input logic [15:0] i_nearest_index
);
    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_found)
            && $stable(i_nearest_index))
        else $error("result changed while stalled");

    // no winner reports index zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_nearest_index == 16'd0)
        else $error("nonzero index without a winner");

    // busy right after taking a point
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after accept");

    // reset empties the result register
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind nearest_point_to_line npl_props u_npl_props (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pt.valid),
    .i_in_ready      (i_pt.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_found         (o_res.found),
    .i_nearest_index (o_res.nearest_index)
);

// ===== tb/npl_checker.sv =====
module npl_checker
    import npl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_idx,
    input  logic [DIST_W-1:0]   i_cfg_data,
    npl_point_if                i_pt,
    npl_result_if               i_res,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  nearest_index;
    } t_pick;

    logic signed [31:0] line_s [3];
    logic signed [31:0] line_e [3];
    logic [DIST_W-1:0]  thresh;
    logic [IDX_W-1:0]   position;
    logic [DIST_W-1:0]  best_dist;
    logic [IDX_W-1:0]   best_pos;
    logic               have_best;
    t_pick              pick_q [$];

    // squared distance of a point to the current line, Q32.32, saturating
    function automatic logic [DIST_W-1:0] line_dist2(logic signed [31:0] px,
            logic signed [31:0] py, logic signed [31:0] pz);
        logic signed [33:0]  dx, dy, dz, qx, qy, qz;
        logic signed [69:0]  cx, cy, cz;
        logic signed [141:0] acc;
        logic [141:0]        num, den, quo;
        dx = line_e[0] - line_s[0];
        dy = line_e[1] - line_s[1];
        dz = line_e[2] - line_s[2];
        qx = px - line_s[0];
        qy = py - line_s[1];
        qz = pz - line_s[2];
        acc = dx * dx + dy * dy + dz * dz;
        den = acc;
        if (den == 0) begin
            acc = qx * qx + qy * qy + qz * qz;
            num = acc;
            return (num[141:64] != 0) ? DIST_SAT : num[63:0];
        end
        cx = dy * qz - dz * qy;
        cy = dz * qx - dx * qz;
        cz = dx * qy - dy * qx;
        acc = cx * cx + cy * cy + cz * cz;
        num = acc;
        quo = num / den;
        return (quo[141:64] != 0) ? DIST_SAT : quo[63:0];
    endfunction

    always_ff @(posedge i_clk) begin
        t_pick             got, want;
        logic [DIST_W-1:0] d, limit;
        int                popped, pushed;
        popped = 0;
        pushed = 0;
        if (!i_rst_n) begin
            foreach (line_s[k]) begin
                line_s[k] <= '0;
                line_e[k] <= '0;
            end
            thresh <= THRESH_RESET;
            position <= '0;
            best_dist <= THRESH_RESET;
            best_pos <= '0;
            have_best <= 1'b0;
            pick_q.delete();
            o_fail_count <= 0;
            o_pending <= 0;
            o_result_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_START_X: line_s[0] <= i_cfg_data[31:0];
                    REG_START_Y: line_s[1] <= i_cfg_data[31:0];
                    REG_START_Z: line_s[2] <= i_cfg_data[31:0];
                    REG_END_X:   line_e[0] <= i_cfg_data[31:0];
                    REG_END_Y:   line_e[1] <= i_cfg_data[31:0];
                    REG_END_Z:   line_e[2] <= i_cfg_data[31:0];
                    REG_THRESH:  thresh <= i_cfg_data;
                    default: ;
                endcase
            end
            // outgoing word first: it can never belong to this edge's input
            if (i_res.valid && i_res.ready) begin
                got.found = i_res.found;
                got.nearest_index = i_res.nearest_index;
                o_result_count <= o_result_count + 1;
                if (pick_q.size() == 0) begin
                    $display("%0t: unexpected result found=%0b index=%0d",
                             $time, got.found, got.nearest_index);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pick_q.pop_front();
                    popped = 1;
                    if (got !== want) begin
                        $display("%0t: result mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                                 $time, want.found, want.nearest_index,
                                 got.found, got.nearest_index);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_pt.valid && i_pt.ready) begin
                logic              nf;
                logic [DIST_W-1:0] nb;
                logic [IDX_W-1:0]  np;
                nf = have_best;
                nb = best_dist;
                np = best_pos;
                if (i_pt.visible) begin
                    d = line_dist2(i_pt.point_x, i_pt.point_y, i_pt.point_z);
                    limit = have_best ? best_dist : thresh;
                    if (d < limit) begin
                        nb = d;
                        np = position;
                        nf = 1'b1;
                    end
                end
                if (i_pt.last) begin
                    want.found = nf;
                    want.nearest_index = nf ? np : '0;
                    pick_q.push_back(want);
                    pushed = 1;
                    position <= '0;
                    best_dist <= thresh;
                    best_pos <= '0;
                    have_best <= 1'b0;
                end else begin
                    position <= position + 1'b1;
                    best_dist <= nb;
                    best_pos <= np;
                    have_best <= nf;
                end
            end
            o_pending <= o_pending + pushed - popped;
        end
    end
endmodule

// ===== tb/tb_nearest_point_to_line.sv =====
module tb_nearest_point_to_line;
    import npl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_cfg_idx REG_UNUSED = 3'd7;    // no register behind this index
    localparam int       RUN_LIMIT  = 1_000_000;
    localparam int       DRAIN_WAIT = 200;
    localparam int       PHASE_WORDS = 200;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    t_cfg_idx          cfg_idx;
    logic [DIST_W-1:0] cfg_data;

    int  fail_count, pending, result_count;
    int  sender_idle_pct, recv_stall_pct;
    int  hold_off;             // cycles of forced receiver stall
    int  words_sent;
    longint cycle_count;

    npl_point_if  pt_ch ();
    npl_result_if res_ch ();

    nearest_point_to_line u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pt       (pt_ch.sink),
        .o_res      (res_ch.source)
    );

    npl_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_pt           (pt_ch),
        .i_res          (res_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d results still owed", $time, pending);
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random stalls plus one long forced hold-off in the first random phase
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [DIST_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one word on the point channel; ready is looked at mid-cycle so the
    // accepting edge is known without racing the block's own update
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic vis, logic lst);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            pt_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        pt_ch.valid <= 1'b1;
        pt_ch.point_x <= x;
        pt_ch.point_y <= y;
        pt_ch.point_z <= z;
        pt_ch.visible <= vis;
        pt_ch.last <= lst;
        @(negedge i_clk);
        while (!pt_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
        words_sent++;
    endtask

    task automatic go_idle();
        pt_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // block is quiet: nothing owed and any trailing invisible work done
    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // mostly near the origin so distances land around the thresholds,
    // now and then anywhere in the full range
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return $urandom;
            1: return ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    task automatic random_line();
        t_cfg_idx idx;
        for (int k = 0; k < 6; k++) begin
            idx = t_cfg_idx'(k);
            // occasionally (after the loop) collapse both endpoints onto the origin
            write_reg(idx, {32'h0, pick_coord()});
        end
        case ($urandom_range(3))
            0: write_reg(REG_THRESH, THRESH_RESET);
            1: write_reg(REG_THRESH, 64'h0000_0004_0000_0000);
            2: write_reg(REG_THRESH, {$urandom, $urandom});
            default: write_reg(REG_THRESH, DIST_SAT);
        endcase
        if ($urandom_range(3) == 0) begin
            write_reg(REG_END_X, {32'h0, 32'h0});
            write_reg(REG_END_Y, {32'h0, 32'h0});
            write_reg(REG_END_Z, {32'h0, 32'h0});
            write_reg(REG_START_X, 64'h0);
            write_reg(REG_START_Y, 64'h0);
            write_reg(REG_START_Z, 64'h0);
        end
        end_writes();
    endtask

    // random lists: mostly short and well formed, some single-word runs
    task automatic random_phase(int words);
        int n;
        int left;
        left = words;
        while (left > 0) begin
            n = ($urandom_range(4) == 0) ? 1 : $urandom_range(2, 8);
            for (int k = 0; k < n; k++) begin
                send_point(pick_coord(), pick_coord(), pick_coord(),
                           $urandom_range(9) != 0, k == n - 1);
            end
            left -= n;
        end
    endtask

    initial begin
        hold_off = 0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        words_sent = 0;
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= REG_START_X;
        cfg_data <= '0;
        pt_ch.valid <= 1'b0;
        pt_ch.point_x <= '0;
        pt_ch.point_y <= '0;
        pt_ch.point_z <= '0;
        pt_ch.visible <= 1'b0;
        pt_ch.last <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: reset line is a single point at the origin ----
        send_point(32'h0, 32'h0, 32'h0, 1'b1, 1'b1);           // exact hit, index 0
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b0); // very far: no win
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
        send_point(32'h0000_8000, 32'h0, 32'h0, 1'b1, 1'b0);   // 0.25 wins at 2
        send_point(32'h0000_8000, 32'h0, 32'h0, 1'b1, 1'b0);   // tie keeps 2
        send_point(32'h0, 32'h0, 32'h0, 1'b0, 1'b1);           // invisible closer
        send_point(32'h0001_0000, 32'h0, 32'h0, 1'b1, 1'b1);   // exactly 1.0: no win
        go_idle();
        wait_drained();

        // extreme line, full threshold, unused index ignored
        write_reg(REG_START_X, 64'h0000_0000_8000_0000);
        write_reg(REG_START_Y, 64'h0000_0000_8000_0000);
        write_reg(REG_START_Z, 64'h0000_0000_8000_0000);
        write_reg(REG_END_X, 64'h0000_0000_7fff_ffff);
        write_reg(REG_END_Y, 64'h0000_0000_7fff_ffff);
        write_reg(REG_END_Z, 64'h0000_0000_7fff_ffff);
        write_reg(REG_THRESH, DIST_SAT);
        write_reg(REG_UNUSED, 64'h0);
        end_writes();
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 1'b1, 1'b0);           // on the line
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b1, 1'b1);
        go_idle();
        wait_drained();

        // zero threshold: nothing can win
        write_reg(REG_THRESH, 64'h0);
        end_writes();
        send_point(32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
        send_point(32'hffff_ffff, 32'h1, 32'h0, 1'b1, 1'b1);
        go_idle();
        wait_drained();

        // ---- random phases with different idle patterns ----
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin sender_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            random_line();
            // receiver walks away while short lists keep coming
            if (ph == 0) hold_off = 3000;
            random_phase(PHASE_WORDS);
            if (ph == 1) begin
                // sender waits out every owed result mid-phase
                go_idle();
                while (pending != 0) @(posedge i_clk);
                random_phase(20);
            end
            go_idle();
            wait_drained();
        end

        $display("Sent %0d point words, checked %0d results over directed cases,",
                 words_sent, result_count);
        $display("saturating and coincident lines and four random phases with varied stalls.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
